/* rtl/tmc_pkg.sv */
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types, widths and register defaults for the tilt midpoint calibrator.
// ----------------------------------------------------------------------------
package tmc_pkg;

  // Field widths
  localparam int PITCH_W    = 17;
  localparam int RAW_W      = 16;
  localparam int COUNT_W    = 16;
  localparam int ALPHA_W    = 16;
  localparam int ALPHA_FRAC = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int S_TDATA_W  = 88;
  localparam int M_TDATA_W  = 56;

  // Default parameter values
  localparam int INVALID_RUN_LIMIT_DEF      = 5;
  localparam int FILTER_EXTRA_FRAC_BITS_DEF = 16;

  // Register reset values
  localparam logic [15:0] UPRIGHT_WINDOW_RST     = 16'd3072;
  localparam logic [14:0] GYRO_MAX_RST           = 15'd32;
  localparam logic [31:0] ACCEL_SQ_MIN_RST       = 32'd193945617;
  localparam logic [31:0] ACCEL_SQ_MAX_RST       = 32'd355005891;
  localparam logic [15:0] RANGE_LIMIT_RST        = 16'd205;
  localparam logic [15:0] FILTER_ERROR_LIMIT_RST = 16'd154;
  localparam logic [15:0] STABLE_TARGET_RST      = 16'd300;
  localparam logic [15:0] FILTER_ALPHA_RST       = 16'd2621;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_UPRIGHT_WINDOW     = 3'd0,
    REG_GYRO_MAX           = 3'd1,
    REG_ACCEL_SQ_MIN       = 3'd2,
    REG_ACCEL_SQ_MAX       = 3'd3,
    REG_RANGE_LIMIT        = 3'd4,
    REG_FILTER_ERROR_LIMIT = 3'd5,
    REG_STABLE_TARGET      = 3'd6,
    REG_FILTER_ALPHA       = 3'd7
  } reg_index_t;

  // Configuration bundle
  typedef struct packed {
    logic [15:0] upright_window;
    logic [14:0] gyro_max;
    logic [31:0] accel_sq_min;
    logic [31:0] accel_sq_max;
    logic [15:0] range_limit;
    logic [15:0] filter_error_limit;
    logic [15:0] stable_target;
    logic [ALPHA_W-1:0] filter_alpha;
  } cfg_t;

  // One IMU sample
  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [RAW_W-1:0]   gyro_y_raw;
    logic signed [RAW_W-1:0]   accel_x_raw;
    logic signed [RAW_W-1:0]   accel_y_raw;
    logic signed [RAW_W-1:0]   accel_z_raw;
  } sample_t;

  // Qualified sample handed to the update stage
  typedef struct packed {
    logic                      restart;
    logic                      qual;
    logic signed [PITCH_W-1:0] pitch_angle;
  } stage_t;

  // One result transaction
  typedef struct packed {
    logic                      sample_qualified;
    logic                      midpoint_ready;
    logic                      newly_ready;
    logic signed [PITCH_W-1:0] midpoint_angle;
    logic signed [PITCH_W-1:0] filter_pitch;
    logic [COUNT_W-1:0]        stable_count;
  } result_t;

endpackage

/* rtl/tilt_midpoint_calibrator.sv */
// ----------------------------------------------------------------------------
// tilt_midpoint_calibrator
// Qualifies IMU samples and latches the filtered upright pitch midpoint.
// ----------------------------------------------------------------------------
// A sample accepted on the slave side reaches the master side through the input,
// qualify and result registers. Throughput: one sample per cycle unless m_tready
// stalls the result stream; each register stage holds one transaction and
// advances whenever the stage after it is empty or moving on.
// Reset (rst, synchronous): configuration returns to its defaults, all
// calibration state and the pipeline are cleared.
module tilt_midpoint_calibrator #(
  parameter int INVALID_RUN_LIMIT      = tmc_pkg::INVALID_RUN_LIMIT_DEF,
  parameter int FILTER_EXTRA_FRAC_BITS = tmc_pkg::FILTER_EXTRA_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write port
  input  logic                           cfg_we,
  input  logic [tmc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tmc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Sample stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pitch_angle[16:0], gyro_y_raw[32:17], accel_x_raw[48:33],
  // accel_y_raw[64:49], accel_z_raw[80:65], zero[87:81]
  input  logic [tmc_pkg::S_TDATA_W-1:0]  s_tdata,
  // restart_request[0]
  input  logic                           s_tuser,
  // Result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // sample_qualified[0], midpoint_ready[1], newly_ready[2],
  // midpoint_angle[19:3], filter_pitch[36:20], stable_count[52:37], zero[55:53]
  output logic [tmc_pkg::M_TDATA_W-1:0]  m_tdata
);
  import tmc_pkg::*;

  cfg_t    cfg;
  sample_t s_sample;
  sample_t s1_sample;
  logic    s1_restart;
  logic    v1;
  logic    v2;
  stage_t  s2;
  logic    s1_qual;
  result_t res_next;
  result_t res;
  logic    load1;
  logic    load2;
  logic    load_o;
  logic    step;

  // Unpack the incoming transaction
  always_comb begin
    s_sample.pitch_angle = $signed(s_tdata[16:0]);
    s_sample.gyro_y_raw  = $signed(s_tdata[32:17]);
    s_sample.accel_x_raw = $signed(s_tdata[48:33]);
    s_sample.accel_y_raw = $signed(s_tdata[64:49]);
    s_sample.accel_z_raw = $signed(s_tdata[80:65]);
  end

  tmc_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Stage advance: a stage loads when it is empty or its content moves on
  assign load_o   = !m_tvalid || m_tready;
  assign load2    = !v2 || load_o;
  assign load1    = !v1 || load2;
  assign s_tready = load1;
  assign step     = v2 && load_o;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (load1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (load1 && s_tvalid) begin
      s1_sample  <= s_sample;
      s1_restart <= s_tuser;
    end
  end

  tmc_qualify u_qualify (
    .sample (s1_sample),
    .cfg    (cfg),
    .qual   (s1_qual)
  );

  // Qualify register
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (load2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (load2 && v1) begin
      s2.restart     <= s1_restart;
      s2.qual        <= s1_qual;
      s2.pitch_angle <= s1_sample.pitch_angle;
    end
  end

  tmc_update #(
    .INVALID_RUN_LIMIT      (INVALID_RUN_LIMIT),
    .FILTER_EXTRA_FRAC_BITS (FILTER_EXTRA_FRAC_BITS)
  ) u_update (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .stage  (s2),
    .cfg    (cfg),
    .result (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_o) begin
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

  // Pack the outgoing transaction
  assign m_tdata = {3'b000, res.stable_count, res.filter_pitch, res.midpoint_angle,
                    res.newly_ready, res.midpoint_ready, res.sample_qualified};

`ifndef SYNTH
  // A latch is only reported with the ready flag set and a qualified sample
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.newly_ready |-> res.midpoint_ready && res.sample_qualified)
    else $error("newly_ready without ready flag or qualified sample");

  // State moves only when a transaction enters the result register
  assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("state update without a result");

  // An empty input register always takes a new sample
  assert property (@(posedge clk) disable iff (rst)
    !v1 |-> s_tready)
    else $error("input stalled while empty");

  // Reset leaves no result pending
  assert property (@(posedge clk)
    rst |=> !m_tvalid && !v1 && !v2)
    else $error("pipeline not empty after reset");
`endif

endmodule

/* rtl/tmc_config.sv */
// ----------------------------------------------------------------------------
// tmc_config
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module tmc_config (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tmc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tmc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output tmc_pkg::cfg_t                    cfg
);
  import tmc_pkg::*;

  // Load defaults on reset, else write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upright_window     <= UPRIGHT_WINDOW_RST;
      cfg.gyro_max           <= GYRO_MAX_RST;
      cfg.accel_sq_min       <= ACCEL_SQ_MIN_RST;
      cfg.accel_sq_max       <= ACCEL_SQ_MAX_RST;
      cfg.range_limit        <= RANGE_LIMIT_RST;
      cfg.filter_error_limit <= FILTER_ERROR_LIMIT_RST;
      cfg.stable_target      <= STABLE_TARGET_RST;
      cfg.filter_alpha       <= FILTER_ALPHA_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_addr))
        REG_UPRIGHT_WINDOW:     cfg.upright_window     <= cfg_wdata[15:0];
        REG_GYRO_MAX:           cfg.gyro_max           <= cfg_wdata[14:0];
        REG_ACCEL_SQ_MIN:       cfg.accel_sq_min       <= cfg_wdata[31:0];
        REG_ACCEL_SQ_MAX:       cfg.accel_sq_max       <= cfg_wdata[31:0];
        REG_RANGE_LIMIT:        cfg.range_limit        <= cfg_wdata[15:0];
        REG_FILTER_ERROR_LIMIT: cfg.filter_error_limit <= cfg_wdata[15:0];
        REG_STABLE_TARGET:      cfg.stable_target      <= cfg_wdata[15:0];
        REG_FILTER_ALPHA:       cfg.filter_alpha       <= cfg_wdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/tmc_qualify.sv */
// ----------------------------------------------------------------------------
// tmc_qualify
// Sample qualification: pitch window, gyro limit and squared accel window.
// ----------------------------------------------------------------------------
module tmc_qualify (
  input  tmc_pkg::sample_t sample,
  input  tmc_pkg::cfg_t    cfg,
  output logic             qual
);
  import tmc_pkg::*;

  logic signed [PITCH_W:0] pitch_ext;
  logic signed [PITCH_W:0] window_pos;
  logic signed [PITCH_W:0] window_neg;
  logic signed [RAW_W:0]   gyro_ext;
  logic        [RAW_W:0]   gyro_abs;
  logic signed [31:0]      sq_x;
  logic signed [31:0]      sq_y;
  logic signed [31:0]      sq_z;
  logic        [31:0]      sq_sum;
  logic                    pitch_ok;
  logic                    gyro_ok;
  logic                    accel_ok;

  // Pitch inside the upright window
  assign pitch_ext  = {sample.pitch_angle[PITCH_W-1], sample.pitch_angle};
  assign window_pos = $signed({2'b00, cfg.upright_window});
  assign window_neg = -window_pos;
  assign pitch_ok   = (pitch_ext >= window_neg) && (pitch_ext <= window_pos);

  // Absolute gyro rate within its limit
  assign gyro_ext = {sample.gyro_y_raw[RAW_W-1], sample.gyro_y_raw};
  assign gyro_abs = gyro_ext[RAW_W] ? (RAW_W+1)'(-gyro_ext) : gyro_ext;
  assign gyro_ok  = gyro_abs <= {2'b00, cfg.gyro_max};

  // Squared accel magnitude; the sum of three squares stays below 2^32
  assign sq_x     = sample.accel_x_raw * sample.accel_x_raw;
  assign sq_y     = sample.accel_y_raw * sample.accel_y_raw;
  assign sq_z     = sample.accel_z_raw * sample.accel_z_raw;
  assign sq_sum   = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
  assign accel_ok = (sq_sum >= cfg.accel_sq_min) && (sq_sum <= cfg.accel_sq_max);

  assign qual = pitch_ok && gyro_ok && accel_ok;

endmodule

/* rtl/tmc_update.sv */
// ----------------------------------------------------------------------------
// tmc_update
// Calibration state: invalid run, min/max tracking, exponential filter,
// stable count and midpoint latch. Produces the result of each transaction.
// ----------------------------------------------------------------------------
module tmc_update #(
  parameter int INVALID_RUN_LIMIT      = tmc_pkg::INVALID_RUN_LIMIT_DEF,
  parameter int FILTER_EXTRA_FRAC_BITS = tmc_pkg::FILTER_EXTRA_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  tmc_pkg::stage_t  stage,
  input  tmc_pkg::cfg_t    cfg,
  output tmc_pkg::result_t result
);
  import tmc_pkg::*;

  localparam int FW    = PITCH_W + FILTER_EXTRA_FRAC_BITS;  // filter value
  localparam int DW    = FW + 1;                            // differences
  localparam int PW    = DW + ALPHA_W + 1;                  // alpha product
  localparam int RUN_W = $clog2(INVALID_RUN_LIMIT + 1);

  localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(INVALID_RUN_LIMIT);

  // State
  logic                      started;
  logic [RUN_W-1:0]          run;
  logic signed [FW-1:0]      fval;
  logic [COUNT_W-1:0]        cnt;
  logic signed [PITCH_W-1:0] pmin;
  logic signed [PITCH_W-1:0] pmax;
  logic signed [PITCH_W-1:0] mid;
  logic                      rdy;

  logic                      started_next;
  logic [RUN_W-1:0]          run_next;
  logic signed [FW-1:0]      fval_next;
  logic [COUNT_W-1:0]        cnt_next;
  logic signed [PITCH_W-1:0] pmin_next;
  logic signed [PITCH_W-1:0] pmax_next;
  logic signed [PITCH_W-1:0] mid_next;
  logic                      rdy_next;
  logic                      newly;
  logic                      qual_out;

  // Datapath
  logic signed [FW-1:0]      pe;
  logic signed [DW-1:0]      diff;
  logic signed [PW-1:0]      prod;
  logic signed [DW-1:0]      fnew_w;
  logic signed [FW-1:0]      fnew;
  logic signed [DW-1:0]      err;
  logic        [DW-1:0]      err_abs;
  logic        [DW-1:0]      err_limit;
  logic signed [PITCH_W-1:0] pmin_upd;
  logic signed [PITCH_W-1:0] pmax_upd;
  logic signed [PITCH_W:0]   spread;
  logic [RUN_W-1:0]          run_inc;
  logic [COUNT_W-1:0]        cnt_inc;
  logic                      range_bad;
  logic                      err_bad;

  // Filter step: f' = f + floor(alpha * (P - f) / 2^16)
  assign pe      = $signed({stage.pitch_angle, {FILTER_EXTRA_FRAC_BITS{1'b0}}});
  assign diff    = DW'(pe) - DW'(fval);
  assign prod    = $signed({1'b0, cfg.filter_alpha}) * diff;
  assign fnew_w  = DW'(fval) + $signed(prod[DW+ALPHA_FRAC-1:ALPHA_FRAC]);
  assign fnew    = fnew_w[FW-1:0];
  assign err     = DW'(pe) - DW'(fnew);
  assign err_abs = err[DW-1] ? DW'(-err) : DW'(err);
  assign err_limit = DW'({cfg.filter_error_limit, {FILTER_EXTRA_FRAC_BITS{1'b0}}});
  assign err_bad = err_abs > err_limit;

  // Pitch spread of the candidate
  assign pmin_upd  = (stage.pitch_angle < pmin) ? stage.pitch_angle : pmin;
  assign pmax_upd  = (stage.pitch_angle > pmax) ? stage.pitch_angle : pmax;
  assign spread    = (PITCH_W+1)'(pmax_upd) - (PITCH_W+1)'(pmin_upd);
  assign range_bad = spread > $signed({2'b00, cfg.range_limit});

  // Saturating counters
  assign run_inc = (run < RUN_LIMIT) ? run + 1'b1 : run;
  assign cnt_inc = (cnt < cfg.stable_target) ? cnt + 1'b1 : cnt;

  // Next state
  always_comb begin
    started_next = started;
    run_next     = run;
    fval_next    = fval;
    cnt_next     = cnt;
    pmin_next    = pmin;
    pmax_next    = pmax;
    mid_next     = mid;
    rdy_next     = rdy;
    newly        = 1'b0;
    qual_out     = 1'b0;
    if (stage.restart) begin
      started_next = 1'b0;
      run_next     = '0;
      fval_next    = '0;
      cnt_next     = '0;
      pmin_next    = '0;
      pmax_next    = '0;
      mid_next     = '0;
      rdy_next     = 1'b0;
    end else begin
      qual_out = stage.qual;
      if (!rdy) begin
        if (!stage.qual) begin
          run_next = run_inc;
          // Too many unqualified samples in a row: restart the candidate
          if (run_inc >= RUN_LIMIT) begin
            started_next = 1'b0;
            run_next     = '0;
            fval_next    = '0;
            cnt_next     = '0;
            pmin_next    = '0;
            pmax_next    = '0;
          end
        end else begin
          run_next = '0;
          if (!started) begin
            // First qualified sample seeds the candidate
            fval_next    = pe;
            cnt_next     = COUNT_W'(1);
            started_next = 1'b1;
            pmin_next    = stage.pitch_angle;
            pmax_next    = stage.pitch_angle;
          end else if (range_bad || err_bad) begin
            started_next = 1'b0;
            fval_next    = '0;
            cnt_next     = '0;
            pmin_next    = '0;
            pmax_next    = '0;
          end else begin
            pmin_next = pmin_upd;
            pmax_next = pmax_upd;
            fval_next = fnew;
            cnt_next  = cnt_inc;
            // Enough stable samples: latch the midpoint
            if (cnt_inc >= cfg.stable_target) begin
              mid_next = fnew[FW-1:FILTER_EXTRA_FRAC_BITS];
              rdy_next = 1'b1;
              newly    = 1'b1;
            end
          end
        end
      end
    end
  end

  // Result fields after the update
  always_comb begin
    result.sample_qualified = qual_out;
    result.midpoint_ready   = rdy_next;
    result.newly_ready      = newly;
    result.midpoint_angle   = mid_next;
    result.filter_pitch     = fval_next[FW-1:FILTER_EXTRA_FRAC_BITS];
    result.stable_count     = cnt_next;
  end

  // Advance state once per transaction leaving the update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      run     <= '0;
      fval    <= '0;
      cnt     <= '0;
      pmin    <= '0;
      pmax    <= '0;
      mid     <= '0;
      rdy     <= 1'b0;
    end else if (step) begin
      started <= started_next;
      run     <= run_next;
      fval    <= fval_next;
      cnt     <= cnt_next;
      pmin    <= pmin_next;
      pmax    <= pmax_next;
      mid     <= mid_next;
      rdy     <= rdy_next;
    end
  end

endmodule
